// ===== hdl/svm_pkg.sv =====
package svm_pkg;

    // Machine sizes
    localparam int STACK_DEPTH  = 4096;
    localparam int PROGRAM_SIZE = 65536;
    localparam int ADDR_W       = $clog2(STACK_DEPTH);
    localparam int COUNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int PC_W         = $clog2(PROGRAM_SIZE);

    // Opcodes
    typedef enum logic [4:0] {
        OP_HALT      = 5'd0,
        OP_LIT_INT   = 5'd1,
        OP_CALL      = 5'd2,
        OP_PUT_INT   = 5'd3,
        OP_FRAME     = 5'd4,
        OP_RETURN    = 5'd5,
        OP_JMP       = 5'd6,
        OP_JF        = 5'd7,
        OP_LOCAL_LD  = 5'd8,
        OP_LOCAL_ST  = 5'd9,
        OP_ADD       = 5'd10,
        OP_LESS      = 5'd11,
        OP_RET       = 5'd12,
        OP_LIT_DBL   = 5'd13,
        OP_DBL_INT   = 5'd14,
        OP_PTR_LD    = 5'd15,
        OP_PTR_ST    = 5'd16,
        OP_FPADDR    = 5'd17,
        OP_SUB       = 5'd18,
        OP_MUL       = 5'd19,
        OP_DROP      = 5'd20
    } opcode_t;

    // Status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_BADOP   = 3'd4,
        ST_BADADDR = 3'd5
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_CAP,
        S_EXEC,
        S_WR2,
        S_TOP,
        S_TOPW
    } state_t;

    // Stack read slot selection
    typedef enum logic [1:0] {
        RD_A,
        RD_B,
        RD_C,
        RD_TOP
    } rd_slot_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     load_in;
        logic     rd_en;
        rd_slot_t rd_slot;
        logic     cap1;
        logic     cap2;
        logic     cap3;
        logic     exec;
        logic     wr2;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic [4:0]  operation;
        logic [63:0] argument;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        next_pc;
        logic [2:0]         status;
        logic [12:0]        stack_count;
        logic [63:0]        top_value;
        logic signed [31:0] printed_value;
        logic               printed_valid;
    } out_item_t;

endpackage

// ===== hdl/stack_vm_executor.sv =====
// Channel   Direction  Payload             Handshake
// cmd       in         svm_pkg::in_item_t  cmd_valid / cmd_stall
// res       out        svm_pkg::out_item_t res_valid / res_stall
//
// Each instruction runs three stack reads, execute, a second write,
// a top-of-stack read and the result load, all through the one stack memory port.
// A stalled result holds the sequence in its last step until the result register frees.
// Reset clears the count, frame, pc and stop flag; stack contents are not cleared.
// cmd_stall is high whenever an instruction is in progress.
module stack_vm_executor (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  svm_pkg::in_item_t  cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output svm_pkg::out_item_t res
);

    svm_pkg::cmd_t ctl;

    svm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .ctl       (ctl)
    );

    svm_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .cmd   (cmd),
        .res   (res)
    );

endmodule

// ===== hdl/svm_ctrl.sv =====
module svm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    output logic          res_valid,
    input  logic          res_stall,
    output svm_pkg::cmd_t ctl
);

    svm_pkg::state_t state_reg;
    svm_pkg::state_t state_next;
    logic            res_valid_reg;
    logic            res_valid_next;
    logic            out_free;

    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != svm_pkg::S_IDLE);
    assign res_valid = res_valid_reg;

    // Advance the sequence
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            svm_pkg::S_IDLE: if (cmd_valid) state_next = svm_pkg::S_RD1;
            svm_pkg::S_RD1:  state_next = svm_pkg::S_RD2;
            svm_pkg::S_RD2:  state_next = svm_pkg::S_RD3;
            svm_pkg::S_RD3:  state_next = svm_pkg::S_CAP;
            svm_pkg::S_CAP:  state_next = svm_pkg::S_EXEC;
            svm_pkg::S_EXEC: state_next = svm_pkg::S_WR2;
            svm_pkg::S_WR2:  state_next = svm_pkg::S_TOP;
            svm_pkg::S_TOP:  state_next = svm_pkg::S_TOPW;
            svm_pkg::S_TOPW: if (out_free) state_next = svm_pkg::S_IDLE;
            default:         state_next = svm_pkg::S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        ctl = '0;
        ctl.rd_slot = svm_pkg::RD_A;
        unique case (state_reg)
            svm_pkg::S_IDLE: ctl.load_in = cmd_valid;
            svm_pkg::S_RD1:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_slot = svm_pkg::RD_A;
            end
            svm_pkg::S_RD2:
            begin
                ctl.cap1    = 1'b1;
                ctl.rd_en   = 1'b1;
                ctl.rd_slot = svm_pkg::RD_B;
            end
            svm_pkg::S_RD3:
            begin
                ctl.cap2    = 1'b1;
                ctl.rd_en   = 1'b1;
                ctl.rd_slot = svm_pkg::RD_C;
            end
            svm_pkg::S_CAP:  ctl.cap3 = 1'b1;
            svm_pkg::S_EXEC: ctl.exec = 1'b1;
            svm_pkg::S_WR2:  ctl.wr2 = 1'b1;
            svm_pkg::S_TOP:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_slot = svm_pkg::RD_TOP;
            end
            svm_pkg::S_TOPW: ctl.out_load = out_free;
            default:         ctl.load_in = 1'b0;
        endcase
    end

    // Track the result register
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
        if (ctl.out_load)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= svm_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

// ===== hdl/svm_datapath.sv =====
module svm_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  svm_pkg::cmd_t      ctl,
    input  svm_pkg::in_item_t  cmd,
    output svm_pkg::out_item_t res
);

    localparam int AW = svm_pkg::ADDR_W;
    localparam int CW = svm_pkg::COUNT_W;
    localparam int PW = svm_pkg::PC_W;

    // Value stack memory
    logic [63:0] mem [svm_pkg::STACK_DEPTH];
    logic [63:0] q_reg;

    logic [4:0]    op_reg;
    logic [63:0]   arg_reg;
    logic [63:0]   d1_reg, d2_reg, d3_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] fi_reg;
    logic [PW-1:0] pc_reg;
    logic          stop_reg;
    logic [2:0]    st_reg;
    logic [31:0]   pval_reg;
    logic          pvalid_reg;
    logic          w2_en_reg;
    logic [AW-1:0] w2_addr_reg;
    logic [63:0]   w2_data_reg;
    svm_pkg::out_item_t res_reg;

    // Execute results
    svm_pkg::status_t st;
    logic [CW-1:0] c_new;
    logic [AW-1:0] fi_new;
    logic [PW-1:0] npc;
    logic          w1_en;
    logic [AW-1:0] w1_addr;
    logic [63:0]   w1_data;
    logic          w2_en;
    logic [AW-1:0] w2_addr;
    logic [63:0]   w2_data;
    logic [31:0]   pval;
    logic          pvalid;

    logic [CW-1:0]      cm1, cm2, cinc, cc;
    logic signed [33:0] nx, a_s, t_e, t_r, depth_s;
    logic               a_ge_c, a_ge_cm1, tgt_ok, c_full, c_lt1, c_lt2;
    logic [PW-1:0]      pc_inc;
    logic [31:0]        alu_r, prod;
    logic [AW-1:0]      ra1, ra2, ra3, rtop, mem_addr;
    logic               is_arith;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        sx32 = {{32{v[31]}}, v};
    endfunction

    // Truncate a double toward zero with saturation; a NaN gives zero
    function automatic logic [31:0] dbl_to_int(input logic [63:0] b);
        logic [10:0] ex;
        logic [52:0] man;
        logic [10:0] sh;
        logic [52:0] shifted;
        logic [31:0] mag;
        ex      = b[62:52];
        man     = {1'b1, b[51:0]};
        sh      = 11'd1075 - ex;
        shifted = man >> sh[5:0];
        mag     = shifted[31:0];
        if (ex == 11'h7FF && b[51:0] != 52'd0)
            dbl_to_int = 32'd0;
        else if (ex < 11'd1023)
            dbl_to_int = 32'd0;
        else if (ex >= 11'd1054)
            dbl_to_int = b[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            dbl_to_int = b[63] ? (32'd0 - mag) : mag;
    endfunction

    assign cm1     = cnt_reg - CW'(1);
    assign cm2     = cnt_reg - CW'(2);
    assign cinc    = cnt_reg + CW'(1);
    assign nx      = {{2{arg_reg[31]}}, arg_reg[31:0]};
    assign a_s     = $signed({{(34 - AW){1'b0}}, fi_reg}) + nx;
    assign t_e     = $signed({{(34 - CW){1'b0}}, cnt_reg}) + 34'sd1 + nx;
    assign t_r     = $signed({{(34 - AW){1'b0}}, fi_reg}) - nx - 34'sd1;
    assign depth_s = 34'(svm_pkg::STACK_DEPTH);
    assign a_ge_c  = a_s[33] || (a_s[32:0] >= 33'(cnt_reg));
    assign a_ge_cm1 = a_s[33] || (a_s[32:0] >= 33'(cm1));
    assign tgt_ok  = (arg_reg[31] == 1'b0) && (arg_reg[30:0] < 31'(svm_pkg::PROGRAM_SIZE));
    assign c_full  = (cnt_reg >= CW'(svm_pkg::STACK_DEPTH));
    assign c_lt1   = (cnt_reg == CW'(0));
    assign c_lt2   = (cnt_reg < CW'(2));
    assign pc_inc  = pc_reg + PW'(1);
    assign prod    = d1_reg[31:0] * d2_reg[31:0];
    assign is_arith = (op_reg == svm_pkg::OP_ADD) || (op_reg == svm_pkg::OP_LESS)
                   || (op_reg == svm_pkg::OP_SUB) || (op_reg == svm_pkg::OP_MUL);

    // Select the arithmetic result
    always_comb
    begin
        case (op_reg)
            svm_pkg::OP_ADD:  alu_r = d1_reg[31:0] + d2_reg[31:0];
            svm_pkg::OP_SUB:  alu_r = d1_reg[31:0] - d2_reg[31:0];
            svm_pkg::OP_MUL:  alu_r = prod;
            default:          alu_r = {31'd0,
                                  ($signed(d1_reg[31:0]) < $signed(d2_reg[31:0]))};
        endcase
    end

    // Pick read addresses for each slot
    always_comb
    begin
        if (op_reg == svm_pkg::OP_LOCAL_LD)
            ra1 = a_s[AW-1:0];
        else if (is_arith)
            ra1 = cm2[AW-1:0];
        else
            ra1 = cm1[AW-1:0];
        if (is_arith)
            ra2 = cm1[AW-1:0];
        else if (op_reg == svm_pkg::OP_PTR_ST)
            ra2 = cm2[AW-1:0];
        else
            ra2 = fi_reg - AW'(1);
        if (op_reg == svm_pkg::OP_PTR_LD)
            ra3 = d1_reg[AW-1:0];
        else
            ra3 = fi_reg;
        rtop = cm1[AW-1:0];
        case (ctl.rd_slot)
            svm_pkg::RD_A:  mem_addr = ra1;
            svm_pkg::RD_B:  mem_addr = ra2;
            svm_pkg::RD_C:  mem_addr = ra3;
            default:        mem_addr = rtop;
        endcase
    end

    // Execute one instruction
    always_comb
    begin
        st      = svm_pkg::ST_OK;
        c_new   = cnt_reg;
        fi_new  = fi_reg;
        npc     = pc_inc;
        w1_en   = 1'b0;
        w1_addr = cnt_reg[AW-1:0];
        w1_data = 64'd0;
        w2_en   = 1'b0;
        w2_addr = cm2[AW-1:0];
        w2_data = sx32(d1_reg[31:0]);
        pval    = 32'd0;
        pvalid  = 1'b0;
        cc      = (op_reg == svm_pkg::OP_RET) ? cm1 : cnt_reg;
        if (stop_reg)
            st = svm_pkg::ST_HALT;
        else
        begin
            unique case (op_reg)
                svm_pkg::OP_HALT: st = svm_pkg::ST_HALT;
                svm_pkg::OP_LIT_INT, svm_pkg::OP_LIT_DBL, svm_pkg::OP_FPADDR:
                begin
                    if (c_full)
                        st = svm_pkg::ST_FULL;
                    else
                    begin
                        w1_en = 1'b1;
                        if (op_reg == svm_pkg::OP_LIT_INT)
                            w1_data = sx32(arg_reg[31:0]);
                        else if (op_reg == svm_pkg::OP_LIT_DBL)
                            w1_data = arg_reg;
                        else
                            w1_data = {{30{a_s[33]}}, a_s};
                        c_new = cinc;
                    end
                end
                svm_pkg::OP_CALL:
                begin
                    if (c_full)
                        st = svm_pkg::ST_FULL;
                    else if (!tgt_ok)
                        st = svm_pkg::ST_BADADDR;
                    else
                    begin
                        w1_en   = 1'b1;
                        w1_data = 64'(pc_inc);
                        c_new   = cinc;
                        npc     = arg_reg[PW-1:0];
                    end
                end
                svm_pkg::OP_JMP:
                begin
                    if (!tgt_ok)
                        st = svm_pkg::ST_BADADDR;
                    else
                        npc = arg_reg[PW-1:0];
                end
                svm_pkg::OP_PUT_INT:
                begin
                    if (c_lt1)
                        st = svm_pkg::ST_EMPTY;
                    else
                    begin
                        c_new  = cm1;
                        pval   = d1_reg[31:0];
                        pvalid = 1'b1;
                    end
                end
                svm_pkg::OP_FRAME:
                begin
                    if (c_full)
                        st = svm_pkg::ST_FULL;
                    else if (t_e > depth_s)
                        st = svm_pkg::ST_FULL;
                    else if (t_e < 34'sd0)
                        st = svm_pkg::ST_EMPTY;
                    else
                    begin
                        w1_en   = 1'b1;
                        w1_data = 64'(fi_reg);
                        fi_new  = cnt_reg[AW-1:0];
                        c_new   = t_e[CW-1:0];
                    end
                end
                svm_pkg::OP_RETURN, svm_pkg::OP_RET:
                begin
                    if (op_reg == svm_pkg::OP_RET && c_lt1)
                        st = svm_pkg::ST_EMPTY;
                    else if (fi_reg == AW'(0) || CW'(fi_reg) >= cc)
                        st = svm_pkg::ST_BADADDR;
                    else if (d2_reg >= 64'(svm_pkg::PROGRAM_SIZE)
                          || d3_reg >= 64'(svm_pkg::STACK_DEPTH))
                        st = svm_pkg::ST_BADADDR;
                    else if (t_r < 34'sd0)
                        st = svm_pkg::ST_EMPTY;
                    else if (t_r > depth_s
                          || (op_reg == svm_pkg::OP_RET && t_r >= depth_s))
                        st = svm_pkg::ST_FULL;
                    else
                    begin
                        npc    = d2_reg[PW-1:0];
                        fi_new = d3_reg[AW-1:0];
                        if (op_reg == svm_pkg::OP_RET)
                        begin
                            w1_en   = 1'b1;
                            w1_addr = t_r[AW-1:0];
                            w1_data = d1_reg;
                            c_new   = t_r[CW-1:0] + CW'(1);
                        end
                        else
                            c_new = t_r[CW-1:0];
                    end
                end
                svm_pkg::OP_JF:
                begin
                    if (c_lt1)
                        st = svm_pkg::ST_EMPTY;
                    else if (d1_reg[31:0] == 32'd0 && !tgt_ok)
                        st = svm_pkg::ST_BADADDR;
                    else
                    begin
                        if (d1_reg[31:0] == 32'd0)
                            npc = arg_reg[PW-1:0];
                        c_new = cm1;
                    end
                end
                svm_pkg::OP_LOCAL_LD:
                begin
                    if (a_ge_c)
                        st = svm_pkg::ST_BADADDR;
                    else if (c_full)
                        st = svm_pkg::ST_FULL;
                    else
                    begin
                        w1_en   = 1'b1;
                        w1_data = d1_reg;
                        c_new   = cinc;
                    end
                end
                svm_pkg::OP_LOCAL_ST:
                begin
                    if (c_lt1)
                        st = svm_pkg::ST_EMPTY;
                    else if (a_ge_cm1)
                        st = svm_pkg::ST_BADADDR;
                    else
                    begin
                        w1_en   = 1'b1;
                        w1_addr = a_s[AW-1:0];
                        w1_data = d1_reg;
                        c_new   = cm1;
                    end
                end
                svm_pkg::OP_ADD, svm_pkg::OP_LESS, svm_pkg::OP_SUB, svm_pkg::OP_MUL:
                begin
                    if (c_lt2)
                        st = svm_pkg::ST_EMPTY;
                    else
                    begin
                        w1_en   = 1'b1;
                        w1_addr = cm2[AW-1:0];
                        w1_data = sx32(alu_r);
                        c_new   = cm1;
                    end
                end
                svm_pkg::OP_DBL_INT:
                begin
                    if (c_lt1)
                        st = svm_pkg::ST_EMPTY;
                    else
                    begin
                        w1_en   = 1'b1;
                        w1_addr = cm1[AW-1:0];
                        w1_data = sx32(dbl_to_int(d1_reg));
                    end
                end
                svm_pkg::OP_PTR_LD:
                begin
                    if (c_lt1)
                        st = svm_pkg::ST_EMPTY;
                    else if (d1_reg >= 64'(cm1))
                        st = svm_pkg::ST_BADADDR;
                    else
                    begin
                        w1_en   = 1'b1;
                        w1_addr = cm1[AW-1:0];
                        w1_data = sx32(d3_reg[31:0]);
                    end
                end
                svm_pkg::OP_PTR_ST:
                begin
                    if (c_lt2)
                        st = svm_pkg::ST_EMPTY;
                    else if (d2_reg >= 64'(cm2))
                        st = svm_pkg::ST_BADADDR;
                    else
                    begin
                        w1_en   = 1'b1;
                        w1_addr = d2_reg[AW-1:0];
                        w1_data = sx32(d1_reg[31:0]);
                        w2_en   = 1'b1;
                        c_new   = cm1;
                    end
                end
                svm_pkg::OP_DROP:
                begin
                    if (c_lt1)
                        st = svm_pkg::ST_EMPTY;
                    else
                        c_new = cm1;
                end
                default: st = svm_pkg::ST_BADOP;
            endcase
        end
        // Drop all effects on halt or error
        if (st != svm_pkg::ST_OK)
        begin
            npc    = pc_reg;
            c_new  = cnt_reg;
            fi_new = fi_reg;
            w1_en  = 1'b0;
            w2_en  = 1'b0;
            pval   = 32'd0;
            pvalid = 1'b0;
        end
    end

    // Single-port stack access
    always_ff @(posedge clk)
    begin
        if (ctl.exec && w1_en)
            mem[w1_addr] <= w1_data;
        else if (ctl.wr2 && w2_en_reg)
            mem[w2_addr_reg] <= w2_data_reg;
        else if (ctl.rd_en)
            q_reg <= mem[mem_addr];
    end

    // Capture instruction, read data, execute results and the result item
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            op_reg  <= cmd.operation;
            arg_reg <= cmd.argument;
        end
        if (ctl.cap1)
            d1_reg <= q_reg;
        if (ctl.cap2)
            d2_reg <= q_reg;
        if (ctl.cap3)
            d3_reg <= q_reg;
        if (ctl.exec)
        begin
            st_reg      <= st;
            pval_reg    <= pval;
            pvalid_reg  <= pvalid;
            w2_addr_reg <= w2_addr;
            w2_data_reg <= w2_data;
        end
        if (ctl.out_load)
        begin
            res_reg.next_pc       <= pc_reg;
            res_reg.status        <= st_reg;
            res_reg.stack_count   <= cnt_reg;
            res_reg.top_value     <= (cnt_reg == CW'(0)) ? 64'd0 : q_reg;
            res_reg.printed_value <= pval_reg;
            res_reg.printed_valid <= pvalid_reg;
        end
    end

    // Machine state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            fi_reg    <= '0;
            pc_reg    <= '0;
            stop_reg  <= 1'b0;
            w2_en_reg <= 1'b0;
        end
        else if (ctl.exec)
        begin
            cnt_reg   <= c_new;
            fi_reg    <= fi_new;
            pc_reg    <= npc;
            stop_reg  <= stop_reg || (st != svm_pkg::ST_OK);
            w2_en_reg <= w2_en;
        end
    end

    assign res = res_reg;

endmodule
